### rtl/assert_macros.svh
// assertion macros used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, prop, msg)
`endif
`endif

### rtl/ihcp_pkg.sv
// types and constants of the ip header chain parser
`timescale 1ns / 1ps
package ihcp_pkg;

  localparam int IPV6_FIXED_HDR_BYTES = 40;
  localparam int MAX_HDR_BYTES        = 1024;

  // link layer protocol codes
  localparam logic [1:0] PROTO_IPV4 = 2'd0;
  localparam logic [1:0] PROTO_IPV6 = 2'd1;

  // next header codes
  localparam logic [7:0] NH_HOPOPTS  = 8'd0;
  localparam logic [7:0] NH_TCP      = 8'd6;
  localparam logic [7:0] NH_UDP      = 8'd17;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_AH       = 8'd51;
  localparam logic [7:0] NH_DSTOPTS  = 8'd60;

  // result kinds
  localparam logic [2:0] KIND_TCP      = 3'd0;
  localparam logic [2:0] KIND_UDP      = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd2;
  localparam logic [2:0] KIND_NOT_IP   = 3'd3;
  localparam logic [2:0] KIND_TRUNC    = 3'd4;
  localparam logic [2:0] KIND_TOO_LONG = 3'd5;

  typedef struct packed {
    logic [1:0] net_proto;
    logic [7:0] pkt_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic        ip_version;
    logic [10:0] payload_offset;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } out_beat_t;

endpackage

### rtl/ip_header_chain_parser_core.sv
// ip header chain parser: byte-serial ipv4/ipv6 header and extension chain walker
// result: the completing beat's result is registered in the output or skid stage
// throughput: one packet byte per cycle while the skid stage is empty; bytes keep
//   flowing while the output register holds a result, until the one-entry skid fills
// reset: synchronous, clears the parser to idle (waiting for a first byte), no result
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ip_header_chain_parser_core
  import ihcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  output logic      pkt_ready,
  input  in_beat_t  pkt,
  output logic      res_valid,
  input  logic      res_ready,
  output out_beat_t res
);

  // transport class of a final next header
  function automatic logic [2:0] transport_kind(input logic [7:0] nh);
    logic [2:0] k;
    case (nh)
      NH_TCP:  k = KIND_TCP;
      NH_UDP:  k = KIND_UDP;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // headers that the chain walk steps over
  function automatic logic is_ext(input logic [7:0] nh);
    return (nh == NH_HOPOPTS) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT) ||
           (nh == NH_AH) || (nh == NH_DSTOPTS);
  endfunction

  // parser state
  logic [10:0] byte_index, byte_index_next;
  logic [7:0]  cur_nh, cur_nh_next;
  logic [10:0] hdr_start, hdr_start_next;
  logic [3:0]  hdr_words, hdr_words_next;
  logic [7:0]  pend_next, pend_next_next;
  logic [63:0] src_hi, src_hi_next, src_lo, src_lo_next;
  logic [63:0] dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic        is_v6, is_v6_next;
  logic        parse_done, parse_done_next;

  // output register and skid stage
  logic        out_valid, skid_valid;
  out_beat_t   out_q, skid_q;

  // per-beat working values
  logic        accept;
  logic        res_hit;
  out_beat_t   res_beat;
  logic        done_now;
  logic [10:0] v4_len;
  logic [10:0] v4_end;
  logic [11:0] ext_size;
  logic [11:0] ext_end;

  assign pkt_ready = !skid_valid;
  assign accept    = pkt_valid && pkt_ready;
  assign res_valid = out_valid;
  assign res       = out_q;

  always_comb begin
    byte_index_next = byte_index;
    cur_nh_next     = cur_nh;
    hdr_start_next  = hdr_start;
    hdr_words_next  = hdr_words;
    pend_next_next  = pend_next;
    src_hi_next     = src_hi;
    src_lo_next     = src_lo;
    dst_hi_next     = dst_hi;
    dst_lo_next     = dst_lo;
    is_v6_next      = is_v6;
    parse_done_next = parse_done;
    res_hit         = 1'b0;
    res_beat        = '0;
    done_now        = 1'b0;
    v4_len          = '0;
    v4_end          = '0;
    ext_size        = '0;
    ext_end         = '0;

    // a first byte restarts the parser whatever state it is in
    if (accept && pkt.first_byte) begin
      byte_index_next = '0;
      cur_nh_next     = '0;
      hdr_start_next  = 11'(IPV6_FIXED_HDR_BYTES);
      hdr_words_next  = '0;
      pend_next_next  = '0;
      src_hi_next     = '0;
      src_lo_next     = '0;
      dst_hi_next     = '0;
      dst_lo_next     = '0;
      is_v6_next      = (pkt.net_proto == PROTO_IPV6);
      parse_done_next = 1'b0;
    end

    if (accept && pkt.first_byte && pkt.net_proto != PROTO_IPV4 &&
        pkt.net_proto != PROTO_IPV6) begin
      // not an ip packet: report at once, everything else zero
      is_v6_next           = 1'b0;
      parse_done_next      = 1'b1;
      res_hit              = 1'b1;
      res_beat.result_kind = KIND_NOT_IP;
    end else if (accept && (pkt.first_byte || !parse_done)) begin
      if (!is_v6_next) begin
        // ipv4: ihl, protocol, then the two 32-bit addresses
        if (byte_index_next == 11'd0) begin
          hdr_words_next = pkt.pkt_byte[3:0];
        end else if (byte_index_next == 11'd9) begin
          cur_nh_next = pkt.pkt_byte;
        end else if (byte_index_next >= 11'd12 && byte_index_next <= 11'd15) begin
          src_lo_next = {32'd0, src_lo_next[23:0], pkt.pkt_byte};
        end else if (byte_index_next >= 11'd16 && byte_index_next <= 11'd19) begin
          dst_lo_next = {32'd0, dst_lo_next[23:0], pkt.pkt_byte};
        end
        v4_len = {5'd0, hdr_words_next, 2'b00};
        // header ends at ihl*4-1, but never before the address bytes are in
        v4_end = (v4_len > 11'd20) ? v4_len - 11'd1 : 11'd19;
        if (byte_index_next == v4_end) begin
          done_now                = 1'b1;
          res_beat.result_kind    = transport_kind(cur_nh_next);
          res_beat.ip_version     = 1'b0;
          res_beat.payload_offset = v4_len;
          res_beat.src_hi         = src_hi_next;
          res_beat.src_lo         = src_lo_next;
          res_beat.dst_hi         = dst_hi_next;
          res_beat.dst_lo         = dst_lo_next;
        end
      end else begin
        // ipv6 fixed header: next header, then 16-byte addresses in halves
        if (byte_index_next == 11'd6) begin
          cur_nh_next = pkt.pkt_byte;
        end else if (byte_index_next >= 11'd8 && byte_index_next <= 11'd15) begin
          src_hi_next = {src_hi_next[55:0], pkt.pkt_byte};
        end else if (byte_index_next >= 11'd16 && byte_index_next <= 11'd23) begin
          src_lo_next = {src_lo_next[55:0], pkt.pkt_byte};
        end else if (byte_index_next >= 11'd24 && byte_index_next <= 11'd31) begin
          dst_hi_next = {dst_hi_next[55:0], pkt.pkt_byte};
        end else if (byte_index_next >= 11'd32 && byte_index_next <= 11'd39) begin
          dst_lo_next = {dst_lo_next[55:0], pkt.pkt_byte};
        end

        // extension chain: next header byte, then the length byte
        if (byte_index_next >= 11'(IPV6_FIXED_HDR_BYTES)) begin
          if (byte_index_next == hdr_start_next) begin
            pend_next_next = pkt.pkt_byte;
          end else if ({1'b0, byte_index_next} == {1'b0, hdr_start_next} + 12'd1) begin
            case (cur_nh_next)
              NH_FRAGMENT: ext_size = 12'd8;
              NH_AH:       ext_size = ({4'd0, pkt.pkt_byte} + 12'd2) << 2;
              default:     ext_size = ({4'd0, pkt.pkt_byte} + 12'd1) << 3;
            endcase
            ext_end = {1'b0, hdr_start_next} + ext_size;
            if (ext_end > 12'(MAX_HDR_BYTES)) begin
              done_now                = 1'b1;
              res_beat.result_kind    = KIND_TOO_LONG;
              res_beat.ip_version     = 1'b1;
              res_beat.payload_offset = '0;
              res_beat.src_hi         = src_hi_next;
              res_beat.src_lo         = src_lo_next;
              res_beat.dst_hi         = dst_hi_next;
              res_beat.dst_lo         = dst_lo_next;
            end else begin
              hdr_start_next = ext_end[10:0];
              cur_nh_next    = pend_next_next;
            end
          end
        end

        // last byte of a header whose successor is not an extension
        if (!done_now && ({1'b0, byte_index_next} + 12'd1 == {1'b0, hdr_start_next}) &&
            ({1'b0, byte_index_next} + 12'd1 >= 12'(IPV6_FIXED_HDR_BYTES)) &&
            !is_ext(cur_nh_next)) begin
          done_now                = 1'b1;
          res_beat.result_kind    = transport_kind(cur_nh_next);
          res_beat.ip_version     = 1'b1;
          res_beat.payload_offset = hdr_start_next;
          res_beat.src_hi         = src_hi_next;
          res_beat.src_lo         = src_lo_next;
          res_beat.dst_hi         = dst_hi_next;
          res_beat.dst_lo         = dst_lo_next;
        end
      end

      // byte counter saturates at its top value
      if (byte_index_next != 11'h7FF) begin
        byte_index_next = byte_index_next + 11'd1;
      end

      if (done_now) begin
        parse_done_next = 1'b1;
        res_hit         = 1'b1;
      end else if (pkt.last_byte) begin
        // packet ended before the headers did
        parse_done_next         = 1'b1;
        res_hit                 = 1'b1;
        res_beat                = '0;
        res_beat.result_kind    = KIND_TRUNC;
        res_beat.ip_version     = is_v6_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      cur_nh     <= '0;
      hdr_start  <= '0;
      hdr_words  <= '0;
      pend_next  <= '0;
      src_hi     <= '0;
      src_lo     <= '0;
      dst_hi     <= '0;
      dst_lo     <= '0;
      is_v6      <= 1'b0;
      parse_done <= 1'b1;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      byte_index <= byte_index_next;
      cur_nh     <= cur_nh_next;
      hdr_start  <= hdr_start_next;
      hdr_words  <= hdr_words_next;
      pend_next  <= pend_next_next;
      src_hi     <= src_hi_next;
      src_lo     <= src_lo_next;
      dst_hi     <= dst_hi_next;
      dst_lo     <= dst_lo_next;
      is_v6      <= is_v6_next;
      parse_done <= parse_done_next;
      if (accept && res_hit) begin
        // new result goes to the output unless that one is stuck
        if (!out_valid || res_ready) begin
          out_q     <= res_beat;
          out_valid <= 1'b1;
        end else begin
          skid_q     <= res_beat;
          skid_valid <= 1'b1;
        end
      end else if (out_valid && res_ready) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  `ASSERT_NEVER(a_skid_needs_out, clk, rst, skid_valid && !out_valid, "skid full, output empty")
  `ASSERT_HOLDS(a_hdr_in_range, clk, rst, hdr_start <= 11'(MAX_HDR_BYTES), "header start past limit")
  `ASSERT_HOLDS(a_done_after_result, clk, rst, (accept && res_hit) |=> parse_done, "parser still live after result")
  `ASSERT_HOLDS(a_stall_to_skid, clk, rst, (accept && res_hit && out_valid && !res_ready) |=> skid_valid, "stalled result lost")

endmodule

### bench/tb_top.sv
// self-checking bench for the ip header chain parser: directed and random packets vs a predictor
`timescale 1ns / 1ps
module tb_top;
  import ihcp_pkg::*;

  // link codes that are not ip, and the esp and no-next-header codes (absent from the package)
  localparam logic [1:0] PROTO_OTHER = 2'd2;
  localparam logic [1:0] PROTO_RSVD  = 2'd3;
  localparam logic [7:0] NH_ESP      = 8'd50;
  localparam logic [7:0] NH_NONE     = 8'd59;

  // byte fill patterns for header bodies
  localparam int FILL_RAND = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  localparam int ITEM_TARGET  = 1550;
  localparam int RAND_RESULTS = 8;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 500000;

  // mirror of the parser: tracks one packet and queues the result it should give
  class parse_scoreboard;
    logic [10:0] byte_idx;
    logic [7:0]  next_hdr;
    logic [7:0]  pend_hdr;
    int          ext_start;
    logic [3:0]  ihl;
    logic [63:0] src_w[2];
    logic [63:0] dst_w[2];
    bit          v6;
    bit          idle;
    out_beat_t   pending_q[$];
    int          n_results;
    int          n_mismatch;

    function new();
      clear_packet();
      n_results  = 0;
      n_mismatch = 0;
    endfunction

    function void clear_packet();
      byte_idx  = '0;
      next_hdr  = '0;
      pend_hdr  = '0;
      ext_start = 0;
      ihl       = '0;
      src_w[0]  = '0;
      src_w[1]  = '0;
      dst_w[0]  = '0;
      dst_w[1]  = '0;
      v6        = 1'b0;
      idle      = 1'b1;
    endfunction

    function logic [2:0] transport_of(logic [7:0] nh);
      if (nh == NH_TCP) return KIND_TCP;
      if (nh == NH_UDP) return KIND_UDP;
      return KIND_UNKNOWN;
    endfunction

    function bit is_ext_hdr(logic [7:0] nh);
      return nh == NH_HOPOPTS || nh == NH_ROUTING || nh == NH_FRAGMENT ||
             nh == NH_AH || nh == NH_DSTOPTS;
    endfunction

    function void expect_result(logic [2:0] kind, bit ver, int off, bit with_addr);
      out_beat_t r;
      r.result_kind    = kind;
      r.ip_version     = ver;
      r.payload_offset = 11'(off);
      r.src_hi         = with_addr ? src_w[0] : '0;
      r.src_lo         = with_addr ? src_w[1] : '0;
      r.dst_hi         = with_addr ? dst_w[0] : '0;
      r.dst_lo         = with_addr ? dst_w[1] : '0;
      pending_q.insert(pending_q.size(), r);
      n_results++;
    endfunction

    // returns 1 when the byte belongs to a live packet, 0 when it is ignored
    function bit note_beat(in_beat_t b);
      int i;
      int end_at;
      int span;
      bit done;
      done = 1'b0;
      if (b.first_byte) begin
        clear_packet();
        idle      = 1'b0;
        ext_start = IPV6_FIXED_HDR_BYTES;
        if (b.net_proto != PROTO_IPV4 && b.net_proto != PROTO_IPV6) begin
          idle = 1'b1;
          expect_result(KIND_NOT_IP, 1'b0, 0, 1'b0);
          return 1'b1;
        end
        v6 = (b.net_proto == PROTO_IPV6);
      end else if (idle) begin
        return 1'b0;
      end

      i = int'(byte_idx);
      if (!v6) begin
        if (i == 0) ihl = b.pkt_byte[3:0];
        else if (i == 9) next_hdr = b.pkt_byte;
        else if (i >= 12 && i <= 15) src_w[1] = {32'd0, src_w[1][23:0], b.pkt_byte};
        else if (i >= 16 && i <= 19) dst_w[1] = {32'd0, dst_w[1][23:0], b.pkt_byte};
        end_at = int'(ihl) * 4;
        end_at = (end_at > 20) ? end_at - 1 : 19;
        if (i == end_at) begin
          expect_result(transport_of(next_hdr), 1'b0, int'(ihl) * 4, 1'b1);
          done = 1'b1;
        end
      end else begin
        if (i == 6) next_hdr = b.pkt_byte;
        else if (i >= 8 && i <= 23) src_w[(i - 8) / 8] = {src_w[(i - 8) / 8][55:0], b.pkt_byte};
        else if (i >= 24 && i <= 39) dst_w[(i - 24) / 8] = {dst_w[(i - 24) / 8][55:0], b.pkt_byte};
        if (i >= IPV6_FIXED_HDR_BYTES) begin
          if (i == ext_start) begin
            pend_hdr = b.pkt_byte;
          end else if (i == ext_start + 1) begin
            if (next_hdr == NH_FRAGMENT) span = 8;
            else if (next_hdr == NH_AH) span = (int'(b.pkt_byte) + 2) * 4;
            else span = (int'(b.pkt_byte) + 1) * 8;
            if (ext_start + span > MAX_HDR_BYTES) begin
              expect_result(KIND_TOO_LONG, 1'b1, 0, 1'b1);
              done = 1'b1;
            end else begin
              ext_start = ext_start + span;
              next_hdr  = pend_hdr;
            end
          end
        end
        // esp and unknown codes both land on the unknown kind
        if (!done && i + 1 == ext_start && i + 1 >= IPV6_FIXED_HDR_BYTES &&
            !is_ext_hdr(next_hdr)) begin
          expect_result(transport_of(next_hdr), 1'b1, ext_start, 1'b1);
          done = 1'b1;
        end
      end

      if (byte_idx < 11'd2047) byte_idx = byte_idx + 11'd1;
      if (done) begin
        idle = 1'b1;
      end else if (b.last_byte) begin
        idle = 1'b1;
        expect_result(KIND_TRUNC, v6, 0, 1'b0);
      end
      return 1'b1;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t unexpected result: kind %0d ver %0d off %0d", $time,
                   got.result_kind, got.ip_version, got.payload_offset);
        return;
      end
      want = pending_q.pop_front();
      if (want.result_kind !== got.result_kind || want.ip_version !== got.ip_version ||
          want.payload_offset !== got.payload_offset || want.src_hi !== got.src_hi ||
          want.src_lo !== got.src_lo || want.dst_hi !== got.dst_hi ||
          want.dst_lo !== got.dst_lo) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("%0t mismatch exp: kind %0d ver %0d off %0d src %h_%h dst %h_%h", $time,
                   want.result_kind, want.ip_version, want.payload_offset,
                   want.src_hi, want.src_lo, want.dst_hi, want.dst_lo);
          $display("%0t          got: kind %0d ver %0d off %0d src %h_%h dst %h_%h", $time,
                   got.result_kind, got.ip_version, got.payload_offset,
                   got.src_hi, got.src_lo, got.dst_hi, got.dst_lo);
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      pkt_valid;
  logic      pkt_ready;
  in_beat_t  pkt;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res;

  parse_scoreboard sb;
  logic [7:0]      frame[$];   // packet under construction
  bit              running   = 1'b0;
  bit              src_calm  = 1'b0;
  bit              sink_calm = 1'b0;
  int              sent_beats = 0;
  int              cycles     = 0;

  ip_header_chain_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- frame builders

  function logic [7:0] fill_val(int mode);
    if (mode == FILL_ZERO) return 8'h00;
    if (mode == FILL_ONES) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function void put_fill(int n, int mode = FILL_RAND);
    for (int k = 0; k < n; k++) frame.insert(frame.size(), fill_val(mode));
  endfunction

  // ipv4 header of max(20, ihl*4) bytes, then tail payload bytes
  function void build_v4(logic [3:0] ihl, logic [7:0] l4, int mode, int tail);
    int hlen;
    hlen = (int'(ihl) * 4 > 20) ? int'(ihl) * 4 : 20;
    frame.delete();
    put_fill(hlen + tail, mode);
    frame[0] = {frame[0][7:4], ihl};
    frame[9] = l4;
  endfunction

  function void start_v6(logic [7:0] nh, int mode = FILL_RAND);
    frame.delete();
    put_fill(IPV6_FIXED_HDR_BYTES, mode);
    frame[6] = nh;
  endfunction

  // appends one extension of type kind; one that overruns the limit gets only a stub
  function void add_ext(logic [7:0] kind, logic [7:0] nxt, logic [7:0] len,
                        int mode = FILL_RAND);
    int span;
    if (kind == NH_FRAGMENT) span = 8;
    else if (kind == NH_AH) span = (int'(len) + 2) * 4;
    else span = (int'(len) + 1) * 8;
    if (frame.size() + span > MAX_HDR_BYTES) begin
      frame.insert(frame.size(), nxt);
      frame.insert(frame.size(), len);
      put_fill(4, mode);
    end else begin
      frame.insert(frame.size(), nxt);
      frame.insert(frame.size(), len);
      put_fill(span - 2, mode);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // one beat: random gap (none while the source is calm), then hold valid until ready
  task send_beat(input in_beat_t b);
    int gap;
    bit took;
    gap = src_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= b;
    do begin
      @(negedge clk);
      took = pkt_ready;
      @(posedge clk);
    end while (!took);
    void'(sb.note_beat(b));
    sent_beats++;
  endtask

  // first count bytes of the frame, last flag on the final one when close is set
  task send_frame(input logic [1:0] proto, input int count, input bit close);
    in_beat_t b;
    for (int k = 0; k < count; k++) begin
      b.net_proto  = (k == 0) ? proto : 2'($urandom_range(0, 3));
      b.pkt_byte   = frame[k];
      b.first_byte = (k == 0);
      b.last_byte  = close && (k == count - 1);
      send_beat(b);
    end
  endtask

  // bytes outside any packet
  task send_noise(input int n);
    in_beat_t b;
    for (int k = 0; k < n; k++) begin
      b.net_proto  = 2'($urandom_range(0, 3));
      b.pkt_byte   = 8'($urandom_range(0, 255));
      b.first_byte = 1'b0;
      b.last_byte  = 1'($urandom_range(0, 1));
      send_beat(b);
    end
  endtask

  // sender holds off until every predicted result has been seen
  task drain();
    pkt_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  task rand_packet();
    int pick;
    int mode;
    int tail;
    int n_ext;
    logic [3:0] ihl;
    logic [7:0] cur;
    logic [7:0] nxt;
    logic [7:0] last_nh;
    logic [7:0] len;
    logic [1:0] proto;
    logic [7:0] ext_codes[5];
    ext_codes = '{NH_HOPOPTS, NH_ROUTING, NH_FRAGMENT, NH_AH, NH_DSTOPTS};
    if ($urandom_range(0, 5) == 0) src_calm = !src_calm;
    pick = $urandom_range(0, 15);
    mode = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
    tail = $urandom_range(0, 6);
    pick = $urandom_range(0, 99);

    if (pick < 8) begin
      send_noise($urandom_range(1, 4));
      return;
    end
    if (pick < 14) begin
      frame.delete();
      put_fill($urandom_range(1, 4), mode);
      send_frame($urandom_range(0, 1) ? PROTO_OTHER : PROTO_RSVD, frame.size(),
                 1'($urandom_range(0, 1)));
      return;
    end

    if (pick < 50) begin
      // ipv4, mostly legal header lengths
      proto = PROTO_IPV4;
      ihl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
      case ($urandom_range(0, 2))
        0:       cur = NH_TCP;
        1:       cur = NH_UDP;
        default: cur = 8'($urandom_range(0, 255));
      endcase
      build_v4(ihl, cur, mode, tail);
    end else begin
      // ipv6 with a short extension chain of random types
      proto = PROTO_IPV6;
      case ($urandom_range(0, 3))
        0:       last_nh = NH_TCP;
        1:       last_nh = NH_UDP;
        2:       last_nh = NH_ESP;
        default: last_nh = 8'($urandom_range(0, 255));
      endcase
      n_ext = $urandom_range(0, 4);
      cur = (n_ext > 0) ? ext_codes[$urandom_range(0, 4)] : last_nh;
      start_v6(cur, mode);
      for (int e = 0; e < n_ext; e++) begin
        nxt = (e == n_ext - 1) ? last_nh : ext_codes[$urandom_range(0, 4)];
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
        add_ext(cur, nxt, len, mode);
        cur = nxt;
      end
      put_fill(tail, mode);
    end

    // broken packets: cut short with a last byte, or abandoned without one
    pick = $urandom_range(0, 19);
    if (pick < 2) send_frame(proto, $urandom_range(1, frame.size()), 1'b1);
    else if (pick == 2) send_frame(proto, $urandom_range(1, frame.size()), 1'b0);
    else send_frame(proto, frame.size(), 1'b1);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int stall;
    bit got;
    res_ready = 1'b0;
    wait (running);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do begin
        @(negedge clk);
        got = res_valid;
        if (got) sb.check_result(res);
        @(posedge clk);
      end while (!got);
      if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int base_results;
    sb        = new();
    rst       = 1'b1;
    pkt_valid = 1'b0;
    pkt       = '0;
    repeat (5) @(posedge clk);
    rst     <= 1'b0;
    running  = 1'b1;

    // ipv4: tcp, udp with all-ones addresses, longest header with zero addresses
    build_v4(4'd5, NH_TCP, FILL_RAND, 4);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    build_v4(4'd5, NH_UDP, FILL_ONES, 0);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    build_v4(4'd15, 8'h2f, FILL_ZERO, 2);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    // short header lengths still resolve on byte 19
    build_v4(4'd0, NH_TCP, FILL_RAND, 0);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    build_v4(4'd4, NH_UDP, FILL_RAND, 1);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    // ipv4 truncated mid header, and a one-byte packet
    build_v4(4'd5, NH_TCP, FILL_RAND, 0);
    send_frame(PROTO_IPV4, 10, 1'b1);
    send_frame(PROTO_IPV4, 1, 1'b1);
    // not ip, then stray bytes that must be ignored
    send_frame(PROTO_OTHER, 3, 1'b1);
    send_noise(3);
    send_frame(PROTO_RSVD, 2, 1'b0);

    // ipv6 with no extensions
    start_v6(NH_TCP, FILL_ONES);
    put_fill(3, FILL_ONES);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    start_v6(NH_UDP, FILL_ZERO);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    // hop-by-hop, routing, destination options chain
    start_v6(NH_HOPOPTS);
    add_ext(NH_HOPOPTS, NH_ROUTING, 8'd1);
    add_ext(NH_ROUTING, NH_DSTOPTS, 8'd0);
    add_ext(NH_DSTOPTS, NH_UDP, 8'd2);
    put_fill(5);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    // fragment keeps its fixed size whatever its length byte says; ah uses 4-byte units
    start_v6(NH_FRAGMENT);
    add_ext(NH_FRAGMENT, NH_AH, 8'hff);
    add_ext(NH_AH, NH_TCP, 8'd3);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    // esp ends the walk as unknown
    start_v6(NH_ESP);
    put_fill(4);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    start_v6(NH_DSTOPTS);
    add_ext(NH_DSTOPTS, NH_NONE, 8'd0);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    // chains that overrun the header limit
    start_v6(NH_HOPOPTS);
    add_ext(NH_HOPOPTS, NH_TCP, 8'd255);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    start_v6(NH_AH);
    add_ext(NH_AH, NH_UDP, 8'd245);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    // chain that ends exactly on the limit is not too long: cut short, it reports truncated
    start_v6(NH_HOPOPTS);
    add_ext(NH_HOPOPTS, NH_TCP, 8'd122);
    send_frame(PROTO_IPV6, 48, 1'b1);
    // ipv6 truncated inside an extension, and a one-byte packet
    start_v6(NH_ROUTING);
    add_ext(NH_ROUTING, NH_UDP, 8'd2);
    send_frame(PROTO_IPV6, 45, 1'b1);
    send_frame(PROTO_IPV6, 1, 1'b1);
    // packet abandoned by a new first byte
    start_v6(NH_TCP);
    send_frame(PROTO_IPV6, 20, 1'b0);
    build_v4(4'd5, NH_TCP, FILL_RAND, 0);
    send_frame(PROTO_IPV4, frame.size(), 1'b1);
    // trailing payload after the result is ignored
    start_v6(NH_UDP);
    put_fill(8);
    send_frame(PROTO_IPV6, frame.size(), 1'b1);
    drain();

    // random packets until the beat budget is spent and RAND_RESULTS random results are predicted
    base_results = sb.n_results;
    while (sent_beats < ITEM_TARGET || sb.n_results - base_results < RAND_RESULTS) begin
      rand_packet();
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.n_mismatch == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
